### rtl/kwsm_pkg.sv
package kwsm_pkg;

  localparam int VALUE_W   = 32;
  localparam int LIST_ID_W = 3;
  localparam int OPCODE_W  = 2;
  localparam int STATUS_W  = 2;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

  localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_POP    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Command broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic                 append;
    logic                 clear;
    logic                 commit;
    logic [LIST_ID_W-1:0] list_id;
    logic [VALUE_W-1:0]   value;
  } cell_cmd_t;

endpackage

### rtl/kwsm_cell.sv
module kwsm_cell import kwsm_pkg::*; #(
  parameter int IDX        = 0,
  parameter int ID_W       = 3,
  parameter int LIST_DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cell_cmd_t                 cmd,
  input  logic [ID_W-1:0]           win_idx,
  input  logic                      cand_in_found,
  input  logic signed [VALUE_W-1:0] cand_in_val,
  input  logic [ID_W-1:0]           cand_in_idx,
  output logic                      cand_out_found,
  output logic signed [VALUE_W-1:0] cand_out_val,
  output logic [ID_W-1:0]           cand_out_idx,
  output logic                      app_ok
);

  localparam int PTR_W = $clog2(LIST_DEPTH);
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);

  logic [VALUE_W-1:0] mem [LIST_DEPTH];
  logic [VALUE_W-1:0] head_data;
  logic [PTR_W-1:0]   head_ptr;
  logic [PTR_W-1:0]   tail_ptr;
  logic [CNT_W-1:0]   count;
  logic               pop_me;
  logic               take;

  assign app_ok = cmd.append && ({{(32-LIST_ID_W){1'b0}}, cmd.list_id} == 32'(IDX))
                  && (count != CNT_W'(LIST_DEPTH));
  assign pop_me = cmd.commit && (win_idx == ID_W'(IDX));

  // Strictly smaller replaces, so on equal heads the lower-numbered list keeps the win.
  assign take = (count != '0) &&
                (!cand_in_found || ($signed(head_data) < cand_in_val));

  always_ff @(posedge clk) begin
    if (app_ok) begin
      mem[tail_ptr] <= cmd.value;
    end
    head_data <= mem[head_ptr];
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cand_out_found <= 1'b1;
      cand_out_val   <= $signed(head_data);
      cand_out_idx   <= ID_W'(IDX);
    end else begin
      cand_out_found <= cand_in_found;
      cand_out_val   <= cand_in_val;
      cand_out_idx   <= cand_in_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      head_ptr <= '0;
      tail_ptr <= '0;
      count    <= '0;
    end else begin
      if (app_ok) begin
        tail_ptr <= (tail_ptr == PTR_W'(LIST_DEPTH - 1)) ? '0 : tail_ptr + 1'b1;
        count    <= count + 1'b1;
      end else if (pop_me) begin
        head_ptr <= (head_ptr == PTR_W'(LIST_DEPTH - 1)) ? '0 : head_ptr + 1'b1;
        count    <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/k_way_sorted_merge_core.sv
// K-way sorted merge: NUM_LISTS FIFO lists of up to LIST_DEPTH signed 32-bit
// values, one list per cell of a chain, each cell with its own memory. A request
// is append (value to list list_id, status full if that list has no room or the
// id names no list), pop (remove and return the smallest head, status empty if
// every list is empty) or clear (empty every list). Requests are taken one at a
// time. Append, clear and the unused opcode go through an execute state, then a
// settle state. A pop sweeps the chain, the running minimum walking it one cell
// per cycle; a commit state makes the winning cell advance its head, and the
// settle state lets its registered read port present the new head. A finished
// result waits in the output register while the next request is accepted.
module k_way_sorted_merge_core import kwsm_pkg::*; #(
  parameter int NUM_LISTS  = 8,
  parameter int LIST_DEPTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // Fields from bit 0: opcode[1:0], list_id[4:2], value[36:5], zero fill.
  input  logic [IN_DATA_W-1:0]  s_tdata,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // Fields from bit 0: popped_value[31:0], status[33:32], zero fill.
  output logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int ID_W = $clog2(NUM_LISTS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_COMMIT,
    S_SETTLE
  } state_t;

  state_t                state;
  logic [OPCODE_W-1:0]   op;
  logic [LIST_ID_W-1:0]  list_id;
  logic [VALUE_W-1:0]    value;
  logic [ID_W-1:0]       sweep_cnt;
  logic [VALUE_W-1:0]    res_value;
  logic [STATUS_W-1:0]   res_status;
  cell_cmd_t             cmd;
  logic [NUM_LISTS-1:0]  app_ok;

  logic                      cf [NUM_LISTS+1];
  logic signed [VALUE_W-1:0] cv [NUM_LISTS+1];
  logic [ID_W-1:0]           ci [NUM_LISTS+1];

  assign s_tready = (state == S_IDLE);

  assign cmd.append  = (state == S_EXEC) && (op == OP_APPEND);
  assign cmd.clear   = (state == S_EXEC) && (op == OP_CLEAR);
  assign cmd.commit  = (state == S_COMMIT) && cf[NUM_LISTS];
  assign cmd.list_id = list_id;
  assign cmd.value   = value;

  // The head of the chain sees no candidate yet.
  assign cf[0] = 1'b0;
  assign cv[0] = '0;
  assign ci[0] = '0;

  for (genvar i = 0; i < NUM_LISTS; i++) begin : g_cell
    kwsm_cell #(
      .IDX        (i),
      .ID_W       (ID_W),
      .LIST_DEPTH (LIST_DEPTH)
    ) u_cell (
      .clk            (clk),
      .rst            (rst),
      .cmd            (cmd),
      .win_idx        (ci[NUM_LISTS]),
      .cand_in_found  (cf[i]),
      .cand_in_val    (cv[i]),
      .cand_in_idx    (ci[i]),
      .cand_out_found (cf[i+1]),
      .cand_out_val   (cv[i+1]),
      .cand_out_idx   (ci[i+1]),
      .app_ok         (app_ok[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      m_tvalid  <= 1'b0;
      sweep_cnt <= '0;
    end else begin
      if (m_tvalid && m_tready && state != S_SETTLE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op        <= s_tdata[1:0];
            list_id   <= s_tdata[4:2];
            value     <= s_tdata[36:5];
            sweep_cnt <= '0;
            state     <= (s_tdata[1:0] == OP_POP) ? S_SWEEP : S_EXEC;
          end
        end
        S_EXEC: begin
          res_value  <= '0;
          res_status <= (cmd.append && !(|app_ok)) ? ST_FULL : ST_OK;
          state      <= S_SETTLE;
        end
        S_SWEEP: begin
          // Each cycle the running minimum moves one cell further down the chain.
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_cnt == ID_W'(NUM_LISTS - 1)) begin
            state <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          res_value  <= cf[NUM_LISTS] ? cv[NUM_LISTS] : '0;
          res_status <= cf[NUM_LISTS] ? ST_OK : ST_EMPTY;
          state      <= S_SETTLE;
        end
        S_SETTLE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {{(OUT_DATA_W - VALUE_W - STATUS_W){1'b0}}, res_status, res_value};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
